>>> design/slps_pkg.sv
// Shared types and constants for the status LED pattern sequencer.
package slps_pkg;

    typedef enum logic [2:0] {
        MODE_BOOT     = 3'd0,
        MODE_ANNOUNCE = 3'd1,
        MODE_REPLACE  = 3'd2,
        MODE_LOW      = 3'd3,
        MODE_LOST     = 3'd4,
        MODE_IDLE     = 3'd5
    } mode_t;

    localparam logic [1:0] LINK_NONE   = 2'd0;
    localparam logic [1:0] LINK_BONDED = 2'd1;
    localparam logic [1:0] LINK_UP     = 2'd2;

    localparam logic [1:0] COL_OFF   = 2'd0;
    localparam logic [1:0] COL_BLUE  = 2'd1;
    localparam logic [1:0] COL_AMBER = 2'd2;
    localparam logic [1:0] COL_GREEN = 2'd3;

    localparam logic [1:0] CFG_SPLIT_PRESENT = 2'd0;
    localparam logic [1:0] CFG_HOST_PRESENT  = 2'd1;
    localparam logic [1:0] CFG_LOW_PCT       = 2'd2;
    localparam logic [1:0] CFG_REPLACE_PCT   = 2'd3;

    localparam logic [14:0] HOLD_ZERO     = 15'd0;
    localparam logic [14:0] HOLD_BOOT     = 15'd3000;
    localparam logic [14:0] HOLD_ANNOUNCE = 15'd1000;
    localparam logic [14:0] HOLD_SLOW     = 15'd250;
    localparam logic [14:0] HOLD_FAST     = 15'd125;
    localparam logic [14:0] HOLD_PULSE    = 15'd120;
    localparam logic [14:0] HOLD_GAP      = 15'd280;
    localparam logic [14:0] HOLD_LOW_REST = 15'd30000;
    localparam logic [14:0] HOLD_REP_REST = 15'd15000;
    localparam logic [14:0] HOLD_IDLE     = 15'd500;

    localparam logic [2:0] PHASES_LOW     = 3'd2;
    localparam logic [2:0] PHASES_REPLACE = 3'd4;

    typedef struct packed {
        logic       split_present;
        logic       host_present;
        logic [6:0] low_pct;
        logic [6:0] replace_pct;
    } cfg_t;

    typedef struct packed {
        logic [1:0] split_state;
        logic [1:0] host_state;
        logic [6:0] charge_percent;
        logic       asleep;
    } item_t;

    typedef struct packed {
        logic [1:0]  rgb_code;
        logic [14:0] hold_ms;
    } result_t;

endpackage

>>> design/status_led_pattern_sequencer.sv
// Status LED pattern sequencer: tick in, LED color and hold time out.
//
// One request on the input channel is one pattern tick: the split and host
// link states, battery charge and sleep flag. Each tick gives exactly one
// result request: an LED color (off, blue, amber, green) and the hold time in
// milliseconds before the next tick should be sent.
// The config channel writes the link-present flags and the two battery
// thresholds; it is always ready and should only be used while idle.
// A tick is captured in the input register and stepped through the pattern
// rule into the result register once the output is free; the result register
// drives out_valid.
// Throughput: one tick per cycle while out_ready stays high; the step rule
// is short combinational logic between the input and result registers.
// Reset: booting state, idle pattern, no pending announcement, both links
// taken as bonded and not connected, thresholds 15 and 5 percent.
// When the receiver stalls, the result register holds its request, the input
// register fills, and in_ready drops until out_ready returns.
module status_led_pattern_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  split_state,
    input  logic [1:0]  host_state,
    input  logic [6:0]  charge_percent,
    input  logic        asleep,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  rgb_code,
    output logic [14:0] hold_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import slps_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_comb;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    in_fire;

    assign advance  = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    slps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slps_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.split_state    <= split_state;
            item_reg.host_state     <= host_state;
            item_reg.charge_percent <= charge_percent;
            item_reg.asleep         <= asleep;
        end
        if (advance)
            res_reg <= res_comb;
    end

    assign out_valid = res_valid_reg;
    assign rgb_code  = res_reg.rgb_code;
    assign hold_ms   = res_reg.hold_ms;

endmodule

>>> design/slps_cfg_regs.sv
// Configuration register file: link presence and battery thresholds.
module slps_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_data,
    output slps_pkg::cfg_t   cfg
);
    import slps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPLIT_PRESENT: cfg_next.split_present = cfg_data[0];
                CFG_HOST_PRESENT:  cfg_next.host_present  = cfg_data[0];
                CFG_LOW_PCT:       cfg_next.low_pct       = cfg_data;
                CFG_REPLACE_PCT:   cfg_next.replace_pct   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split_present <= 1'b1;
            cfg_reg.host_present  <= 1'b1;
            cfg_reg.low_pct       <= 7'd15;
            cfg_reg.replace_pct   <= 7'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/slps_step.sv
// Pattern state and the per-tick step rule (mode priority, pattern phase, hold time).
module slps_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  slps_pkg::cfg_t    cfg,
    input  slps_pkg::item_t   item,
    output slps_pkg::result_t result
);
    import slps_pkg::*;

    logic       boot_reg, boot_next;
    mode_t      mode_reg, mode_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] pend_reg, pend_next;
    logic [1:0] last_split_reg, last_split_next;
    logic [1:0] last_host_reg, last_host_next;

    logic [1:0] split_n;
    logic [1:0] host_n;
    logic       split_down;
    logic       host_down;
    logic [1:0] pend_evt;
    mode_t      prio_mode;
    logic [2:0] step0;
    logic       pick_split;
    logic [1:0] lost_state;
    logic [2:0] phases;
    logic [2:0] bat_s;
    logic [2:0] bat_s1;

    // code 3 counts as connected
    assign split_n = item.split_state[1] ? LINK_UP : item.split_state;
    assign host_n  = item.host_state[1]  ? LINK_UP : item.host_state;

    assign split_down = cfg.split_present && (split_n != LINK_UP);
    assign host_down  = cfg.host_present  && (host_n  != LINK_UP);

    // rising connect edge after boot; host wins when both come back together
    always_comb
    begin
        pend_evt = pend_reg;
        if (cfg.split_present && last_split_reg != LINK_UP
            && split_n == LINK_UP && !boot_reg)
            pend_evt = COL_GREEN;
        if (cfg.host_present && last_host_reg != LINK_UP
            && host_n == LINK_UP && !boot_reg)
            pend_evt = COL_BLUE;
    end

    always_comb
    begin
        if (item.asleep)
            prio_mode = MODE_IDLE;
        else if (boot_reg)
            prio_mode = MODE_BOOT;
        else if (item.charge_percent <= cfg.replace_pct)
            prio_mode = MODE_REPLACE;
        else if (item.charge_percent <= cfg.low_pct)
            prio_mode = MODE_LOW;
        else if (split_down || host_down)
            prio_mode = MODE_LOST;
        else
            prio_mode = MODE_IDLE;
    end

    always_comb
    begin
        boot_next       = boot_reg;
        mode_next       = prio_mode;
        pend_next       = pend_evt;
        last_split_next = cfg.split_present ? split_n : last_split_reg;
        last_host_next  = cfg.host_present  ? host_n  : last_host_reg;
        result.rgb_code = COL_OFF;
        result.hold_ms  = HOLD_IDLE;

        if (!item.asleep)
        begin
            if (pend_evt != COL_OFF && prio_mode == MODE_IDLE)
                mode_next = MODE_ANNOUNCE;
            else if (prio_mode != MODE_IDLE)
                pend_next = COL_OFF;
        end

        step0 = (mode_next != mode_reg) ? 3'd0 : step_reg;
        step_next = step0;

        pick_split = (split_down && host_down) ? !step0[1] : split_down;
        lost_state = pick_split ? split_n : host_n;
        phases = (mode_next == MODE_REPLACE) ? PHASES_REPLACE : PHASES_LOW;
        bat_s  = (step0 >= phases) ? 3'd0 : step0;
        bat_s1 = bat_s + 3'd1;

        case (mode_next)
            MODE_BOOT:
            begin
                result.rgb_code = COL_BLUE;
                if (step0 == 3'd0)
                begin
                    step_next      = 3'd1;
                    result.hold_ms = HOLD_BOOT;
                end
                else
                begin
                    boot_next      = 1'b0;
                    result.hold_ms = HOLD_ZERO;
                end
            end
            MODE_ANNOUNCE:
            begin
                result.rgb_code = pend_evt;
                result.hold_ms  = HOLD_ANNOUNCE;
                pend_next       = COL_OFF;
            end
            MODE_LOST:
            begin
                result.rgb_code = step0[0] ? COL_OFF
                                : (pick_split ? COL_GREEN : COL_BLUE);
                result.hold_ms  = (lost_state == LINK_NONE) ? HOLD_FAST : HOLD_SLOW;
                step_next       = {1'b0, step0[1:0] + 2'd1};
            end
            MODE_REPLACE, MODE_LOW:
            begin
                result.rgb_code = bat_s[0] ? COL_OFF : COL_AMBER;
                if (bat_s1 >= phases)
                begin
                    result.hold_ms = (mode_next == MODE_REPLACE) ? HOLD_REP_REST
                                                                 : HOLD_LOW_REST;
                    step_next      = 3'd0;
                end
                else
                begin
                    result.hold_ms = bat_s[0] ? HOLD_GAP : HOLD_PULSE;
                    step_next      = bat_s1;
                end
            end
            default:
            begin
                result.rgb_code = COL_OFF;
                result.hold_ms  = HOLD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_reg       <= 1'b1;
            mode_reg       <= MODE_IDLE;
            step_reg       <= 3'd0;
            pend_reg       <= COL_OFF;
            last_split_reg <= LINK_BONDED;
            last_host_reg  <= LINK_BONDED;
        end
        else if (step_en)
        begin
            boot_reg       <= boot_next;
            mode_reg       <= mode_next;
            step_reg       <= step_next;
            pend_reg       <= pend_next;
            last_split_reg <= last_split_next;
            last_host_reg  <= last_host_next;
        end
    end

endmodule

>>> design/slps_checker.sv
// Port-level checks for the status LED pattern sequencer, bound to the top level.
module slps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  rgb_code,
    input logic [14:0] hold_ms
);
    import slps_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rgb_code) && $stable(hold_ms))
        else $error("result changed while stalled");

    // input only backs up behind a held result
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // amber is only ever a pulse
    a_amber: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rgb_code == COL_AMBER |-> hold_ms == HOLD_PULSE)
        else $error("amber with wrong hold");

    // boot glow and boot exit are blue; announcement is never dark
    a_boot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hold_ms == HOLD_BOOT || hold_ms == HOLD_ZERO
                      || hold_ms == HOLD_ANNOUNCE)
        |-> rgb_code != COL_OFF && rgb_code != COL_AMBER)
        else $error("boot or announce color wrong");

endmodule

bind status_led_pattern_sequencer slps_checker u_slps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rgb_code  (rgb_code),
    .hold_ms   (hold_ms)
);
